>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("check failed");
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("check failed");
`else
`define CHK_IMPL(label, clk, rst_n, ante, cons)
`define CHK_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> rtl/wofi_pkg.sv
// ----------------------------------------------------------------------------
// wofi_pkg
// Types, constants and commands shared by the order flow imbalance block.
// ----------------------------------------------------------------------------
package wofi_pkg;
    localparam int INSTRUMENTS = 16;
    localparam int RING_DEPTH  = 256;
    localparam int INST_W  = $clog2(INSTRUMENTS);
    localparam int SLOT_W  = $clog2(RING_DEPTH);
    localparam int CNT_W   = SLOT_W + 1;
    localparam int ADDR_W  = INST_W + SLOT_W;
    localparam int TS_W    = 48;
    localparam int QTY_W   = 32;
    localparam int SUM_W   = 40;
    localparam int WIN_W   = 32;
    localparam int BIAS_W  = 16;
    localparam int DIV_W   = SUM_W + 2;
    localparam int QBITS   = 16;
    localparam logic [1:0] SIDE_BUY  = 2'd0;
    localparam logic [1:0] SIDE_SELL = 2'd1;
    localparam logic [31:0] WINDOW_RESET = 32'd1000;

    typedef struct packed {
        logic load;
        logic write_trade;
        logic read_head;
        logic pop_head;
        logic div_start;
        logic div_step;
        logic set_result;
        logic clear_result;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
        logic head_old;
        logic div_done;
        logic in_range;
    } t_status;
endpackage

>>> rtl/wofi_datapath.sv
// ----------------------------------------------------------------------------
// wofi_datapath
// Ring memories, per-instrument counters and sums, and the bias divider.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module wofi_datapath (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  wofi_pkg::t_cmd              i_cmd,
    output wofi_pkg::t_status           o_status,
    input  logic [wofi_pkg::WIN_W-1:0]  i_window,
    input  logic                        i_mode,
    input  logic [3:0]                  i_instrument,
    input  logic [wofi_pkg::TS_W-1:0]   i_timestamp_ms,
    input  logic [wofi_pkg::QTY_W-1:0]  i_trade_qty,
    input  logic [1:0]                  i_aggressor_side,
    output logic [39:0]                 o_buy_sum,
    output logic [39:0]                 o_sell_sum,
    output logic signed [40:0]          o_net_sum,
    output logic [40:0]                 o_total_sum,
    output logic signed [15:0]          o_bias,
    output logic                        o_dropped
);
    import wofi_pkg::*;

    logic [TS_W-1:0]  r_mem_time [0:INSTRUMENTS*RING_DEPTH-1];
    logic [QTY_W-1:0] r_mem_qty  [0:INSTRUMENTS*RING_DEPTH-1];
    logic [1:0]       r_mem_side [0:INSTRUMENTS*RING_DEPTH-1];
    logic [SLOT_W-1:0] r_head [0:INSTRUMENTS-1];
    logic [CNT_W-1:0]  r_cnt  [0:INSTRUMENTS-1];
    logic [SUM_W-1:0]  r_buy  [0:INSTRUMENTS-1];
    logic [SUM_W-1:0]  r_sell [0:INSTRUMENTS-1];

    logic              r_mode;
    logic [3:0]        r_inst_raw;
    logic [INST_W-1:0] r_inst;
    logic [TS_W-1:0]   r_ts;
    logic [QTY_W-1:0]  r_qty;
    logic [1:0]        r_side;
    logic [TS_W-1:0]   r_rd_time;
    logic [QTY_W-1:0]  r_rd_qty;
    logic [1:0]        r_rd_side;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_den;
    logic [QBITS-1:0]  r_quo;
    logic [4:0]        r_step;
    logic              r_neg;

    logic [SLOT_W-1:0] w_tail;
    logic [TS_W-1:0]   w_age;
    logic [SUM_W:0]    w_mag;
    logic [DIV_W-1:0]  w_trial;
    logic [QBITS-1:0]  w_q;
    logic [SUM_W-1:0]  w_b;
    logic [SUM_W-1:0]  w_s;

    assign w_tail = r_head[r_inst] + r_cnt[r_inst][SLOT_W-1:0];
    assign w_age  = r_ts - r_rd_time;
    assign w_b    = r_buy[r_inst];
    assign w_s    = r_sell[r_inst];
    assign w_mag  = (w_s > w_b) ? ({1'b0, w_s} - {1'b0, w_b}) : ({1'b0, w_b} - {1'b0, w_s});
    // The first step yields the integer bit, the remaining steps the fraction bits.
    assign w_trial = (r_step == '0) ? r_rem : {r_rem[DIV_W-2:0], 1'b0};
    assign w_q    = (!r_neg && r_quo > 16'd32767) ? 16'd32767 : r_quo;

    assign o_status.full     = (r_cnt[r_inst] == CNT_W'(RING_DEPTH));
    assign o_status.empty    = (r_cnt[r_inst] == '0);
    assign o_status.head_old = (r_ts > r_rd_time) && (w_age > TS_W'(i_window));
    assign o_status.div_done = (r_step == 5'(QBITS));
    assign o_status.in_range = (32'(r_inst_raw) < 32'(INSTRUMENTS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode     <= i_mode;
            r_inst_raw <= i_instrument;
            r_inst     <= i_instrument[INST_W-1:0];
            r_ts       <= i_timestamp_ms;
            r_qty      <= i_trade_qty;
            r_side     <= i_aggressor_side;
        end
        if (i_cmd.write_trade) begin
            r_mem_time[{r_inst, w_tail}] <= r_ts;
            r_mem_qty[{r_inst, w_tail}]  <= r_qty;
            r_mem_side[{r_inst, w_tail}] <= r_side;
        end
        if (i_cmd.read_head) begin
            r_rd_time <= r_mem_time[{r_inst, r_head[r_inst]}];
            r_rd_qty  <= r_mem_qty[{r_inst, r_head[r_inst]}];
            r_rd_side <= r_mem_side[{r_inst, r_head[r_inst]}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < INSTRUMENTS; k++) begin
                r_head[k] <= '0;
                r_cnt[k]  <= '0;
                r_buy[k]  <= '0;
                r_sell[k] <= '0;
            end
        end else if (i_cmd.write_trade) begin
            r_cnt[r_inst] <= r_cnt[r_inst] + 1'b1;
            if (r_side == SIDE_BUY) begin
                r_buy[r_inst] <= r_buy[r_inst] + SUM_W'(r_qty);
            end else if (r_side == SIDE_SELL) begin
                r_sell[r_inst] <= r_sell[r_inst] + SUM_W'(r_qty);
            end
        end else if (i_cmd.pop_head) begin
            r_cnt[r_inst]  <= r_cnt[r_inst] - 1'b1;
            r_head[r_inst] <= r_head[r_inst] + 1'b1;
            if (r_rd_side == SIDE_BUY) begin
                r_buy[r_inst] <= r_buy[r_inst] - SUM_W'(r_rd_qty);
            end else if (r_rd_side == SIDE_SELL) begin
                r_sell[r_inst] <= r_sell[r_inst] - SUM_W'(r_rd_qty);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_rem  <= DIV_W'(w_mag);
            r_den  <= {1'b0, {1'b0, w_b} + {1'b0, w_s}};
            r_neg  <= (w_s > w_b);
            r_quo  <= '0;
            r_step <= '0;
        end else if (i_cmd.div_step) begin
            if (w_trial >= r_den) begin
                r_rem <= w_trial - r_den;
                r_quo <= {r_quo[QBITS-2:0], 1'b1};
            end else begin
                r_rem <= w_trial;
                r_quo <= {r_quo[QBITS-2:0], 1'b0};
            end
            r_step <= r_step + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_buy_sum   <= '0;
            o_sell_sum  <= '0;
            o_net_sum   <= '0;
            o_total_sum <= '0;
            o_bias      <= '0;
            o_dropped   <= 1'b0;
        end else if (i_cmd.clear_result) begin
            o_buy_sum   <= '0;
            o_sell_sum  <= '0;
            o_net_sum   <= '0;
            o_total_sum <= '0;
            o_bias      <= '0;
            o_dropped   <= o_status.in_range && !r_mode && o_status.full;
        end else if (i_cmd.set_result) begin
            o_buy_sum   <= w_b;
            o_sell_sum  <= w_s;
            o_net_sum   <= $signed({1'b0, w_b}) - $signed({1'b0, w_s});
            o_total_sum <= {1'b0, w_b} + {1'b0, w_s};
            o_bias      <= (r_den == '0) ? '0 : (r_neg ? -$signed(w_q) : $signed(w_q));
            o_dropped   <= 1'b0;
        end
    end

    `CHK_IMPL(a_no_pop_empty, i_clk, i_rst_n, i_cmd.pop_head, !o_status.empty)
    `CHK_IMPL(a_no_write_full, i_clk, i_rst_n, i_cmd.write_trade, !o_status.full)
    `CHK_IMPL(a_div_bound, i_clk, i_rst_n, i_cmd.div_step, r_step < 5'(QBITS))
endmodule

>>> rtl/wofi_ctrl.sv
// ----------------------------------------------------------------------------
// wofi_ctrl
// Sequencer for trade append, query pruning and the bias division.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module wofi_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  logic                i_mode,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    input  wofi_pkg::t_status   i_status,
    output wofi_pkg::t_cmd      o_cmd
);
    import wofi_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DIV0  = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_mode;
    logic       r_valid;
    logic       n_valid;

    assign o_in_stall  = (r_state != S_IDLE) || (r_valid && i_out_stall);
    assign o_out_valid = r_valid;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        n_valid = r_valid && i_out_stall;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && !o_in_stall) begin
                    o_cmd.load = 1'b1;
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!i_status.in_range || !r_mode) begin
                    o_cmd.clear_result = 1'b1;
                    o_cmd.write_trade = i_status.in_range && !r_mode && !i_status.full;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end else if (i_status.empty) begin
                    n_state = S_DIV0;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.read_head = 1'b1;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (i_status.head_old) begin
                    o_cmd.pop_head = 1'b1;
                    n_state = S_DECIDE;
                end else begin
                    n_state = S_DIV0;
                end
            end
            S_DIV0: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_status.div_done) begin
                    n_state = S_OUT;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_OUT: begin
                o_cmd.set_result = 1'b1;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_mode  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (o_cmd.load) begin
                r_mode <= i_mode;
            end
        end
    end

    `CHK_IMPL(a_load_idle, i_clk, i_rst_n, o_cmd.load, r_state == S_IDLE)
    `CHK_NEXT(a_result_set, i_clk, i_rst_n, o_cmd.set_result || o_cmd.clear_result,
              r_valid)
    `CHK_IMPL(a_one_write, i_clk, i_rst_n, o_cmd.write_trade, !o_cmd.pop_head)
endmodule

>>> rtl/windowed_order_flow_imbalance.sv
// Sequence: a trade word is loaded and its result is registered from the decide state;
// a query word runs the ring read loop (read, check and pop of each old entry, skipped
// when the ring is empty) and then the 16-step divider before its result is registered.
// Flow: one word in flight; the next word is accepted together with the result,
// unless the output is stalled.
// Reset is synchronous and active low: rings empty, sums zero, window 1000 ms.
// ----------------------------------------------------------------------------
// windowed_order_flow_imbalance
// Per-instrument trade rings with windowed buy/sell sums and Q1.15 bias.
// ----------------------------------------------------------------------------
module windowed_order_flow_imbalance (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [31:0]        i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_mode,
    input  logic [3:0]         i_instrument,
    input  logic [47:0]        i_timestamp_ms,
    input  logic [31:0]        i_trade_qty,
    input  logic [1:0]         i_aggressor_side,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [39:0]        o_buy_sum,
    output logic [39:0]        o_sell_sum,
    output logic signed [40:0] o_net_sum,
    output logic [40:0]        o_total_sum,
    output logic signed [15:0] o_bias,
    output logic               o_dropped
);
    import wofi_pkg::*;

    logic [WIN_W-1:0] r_window;
    t_cmd             w_cmd;
    t_status          w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (i_cfg_we) begin
            r_window <= i_cfg_wdata;
        end
    end

    wofi_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_mode      (i_mode),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    wofi_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .i_window         (r_window),
        .i_mode           (i_mode),
        .i_instrument     (i_instrument),
        .i_timestamp_ms   (i_timestamp_ms),
        .i_trade_qty      (i_trade_qty),
        .i_aggressor_side (i_aggressor_side),
        .o_buy_sum        (o_buy_sum),
        .o_sell_sum       (o_sell_sum),
        .o_net_sum        (o_net_sum),
        .o_total_sum      (o_total_sum),
        .o_bias           (o_bias),
        .o_dropped        (o_dropped)
    );
endmodule
